// ===== rtl/pfifo_pkg.sv =====
// ----------------------------------------------------------------------------
// pfifo_pkg
// shared types, codes and defaults of the two-class priority fifo
// ----------------------------------------------------------------------------
`default_nettype none

package pfifo_pkg;

	// default sizes
	localparam int DEF_QUEUE_DEPTH = 128;
	localparam int DEF_TAG_BITS    = 32;

	// fixed field widths
	localparam int TAG_W = 32;
	localparam int AGE_W = 8;
	localparam int LVL_W = 8;

	// threshold register
	localparam logic [AGE_W-1:0] SENIOR_RESET  = 8'd60;
	localparam logic             REG_THRESHOLD = 1'b0;

	// request kinds
	typedef enum logic {
		REQ_ADD   = 1'b0,
		REQ_SERVE = 1'b1
	} req_t;

	// queue class
	typedef enum logic {
		CLS_NORMAL = 1'b0,
		CLS_SENIOR = 1'b1
	} cls_t;

	// response status
	typedef enum logic [1:0] {
		RS_ADDED  = 2'd0,
		RS_FULL   = 2'd1,
		RS_SERVED = 2'd2,
		RS_EMPTY  = 2'd3
	} resp_status_t;

	// controller states
	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_RESP = 1'b1
	} fsm_t;

	// one result word
	typedef struct packed {
		resp_status_t      status;
		logic [TAG_W-1:0]  tag;
		logic [AGE_W-1:0]  age;
		cls_t              cls;
		logic [LVL_W-1:0]  senior_level;
		logic [LVL_W-1:0]  normal_level;
	} pfifo_res_t;

endpackage

`default_nettype wire

// ===== rtl/pfifo_mem.sv =====
// ----------------------------------------------------------------------------
// pfifo_mem
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pfifo_mem #(
	parameter int DEPTH = pfifo_pkg::DEF_QUEUE_DEPTH,
	parameter int WIDTH = pfifo_pkg::DEF_TAG_BITS + pfifo_pkg::AGE_W,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pfifo_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfifo_ctrl
// pointer and count keeping for both queues around their two rams
// ----------------------------------------------------------------------------
`default_nettype none

module pfifo_ctrl #(
	parameter int QUEUE_DEPTH = pfifo_pkg::DEF_QUEUE_DEPTH,
	parameter int TAG_BITS    = pfifo_pkg::DEF_TAG_BITS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire pfifo_pkg::req_t                req_type,
	input  wire logic [pfifo_pkg::TAG_W-1:0]    customer_tag,
	input  wire logic [pfifo_pkg::AGE_W-1:0]    age,
	input  wire logic [pfifo_pkg::AGE_W-1:0]    threshold,
	input  wire logic                           res_take,
	output logic                                res_valid,
	output pfifo_pkg::pfifo_res_t               res
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int DW = TAG_BITS + pfifo_pkg::AGE_W;
	localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);

	pfifo_pkg::fsm_t         state_q, state_d;
	logic [AW-1:0]           s_head_q, s_tail_q, n_head_q, n_tail_q;
	logic [CW-1:0]           s_cnt_q, n_cnt_q;
	pfifo_pkg::resp_status_t status_q, status_d;
	pfifo_pkg::cls_t         cls_q, cls_d;

	logic          accept, is_add, to_senior, s_full, n_full, s_empty, n_empty;
	logic          s_we, n_we, s_re, n_re;
	logic [DW-1:0] wdata, s_rdata, n_rdata, rdata;

	// request decode
	always_comb begin
		accept    = s_tvalid && (state_q == pfifo_pkg::FSM_IDLE);
		is_add    = (req_type == pfifo_pkg::REQ_ADD);
		to_senior = (age >= threshold);
		s_full    = (s_cnt_q == FULL_CNT);
		n_full    = (n_cnt_q == FULL_CNT);
		s_empty   = (s_cnt_q == '0);
		n_empty   = (n_cnt_q == '0);
		s_we      = accept && is_add && to_senior && !s_full;
		n_we      = accept && is_add && !to_senior && !n_full;
		s_re      = accept && !is_add && !s_empty;
		n_re      = accept && !is_add && s_empty && !n_empty;
		wdata     = {age, TAG_BITS'(customer_tag)};
	end

	// status and class of the accepted request
	always_comb begin
		if (is_add) begin
			cls_d    = to_senior ? pfifo_pkg::CLS_SENIOR : pfifo_pkg::CLS_NORMAL;
			status_d = (to_senior ? s_full : n_full) ? pfifo_pkg::RS_FULL
			                                         : pfifo_pkg::RS_ADDED;
		end else if (!s_empty) begin
			cls_d    = pfifo_pkg::CLS_SENIOR;
			status_d = pfifo_pkg::RS_SERVED;
		end else if (!n_empty) begin
			cls_d    = pfifo_pkg::CLS_NORMAL;
			status_d = pfifo_pkg::RS_SERVED;
		end else begin
			cls_d    = pfifo_pkg::CLS_NORMAL;
			status_d = pfifo_pkg::RS_EMPTY;
		end
	end

	// queue rams
	pfifo_mem #(.DEPTH(QUEUE_DEPTH), .WIDTH(DW), .AW(AW)) u_senior_mem (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_tail_q),
		.wdata (wdata),
		.re    (s_re),
		.raddr (s_head_q),
		.rdata (s_rdata)
	);

	pfifo_mem #(.DEPTH(QUEUE_DEPTH), .WIDTH(DW), .AW(AW)) u_normal_mem (
		.clk   (clk),
		.we    (n_we),
		.waddr (n_tail_q),
		.wdata (wdata),
		.re    (n_re),
		.raddr (n_head_q),
		.rdata (n_rdata)
	);

	// pointers and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_head_q <= '0;
			s_tail_q <= '0;
			s_cnt_q  <= '0;
			n_head_q <= '0;
			n_tail_q <= '0;
			n_cnt_q  <= '0;
		end else begin
			if (s_we) begin
				s_tail_q <= (s_tail_q == LAST_SLOT) ? '0 : s_tail_q + 1'b1;
				s_cnt_q  <= s_cnt_q + 1'b1;
			end
			if (s_re) begin
				s_head_q <= (s_head_q == LAST_SLOT) ? '0 : s_head_q + 1'b1;
				s_cnt_q  <= s_cnt_q - 1'b1;
			end
			if (n_we) begin
				n_tail_q <= (n_tail_q == LAST_SLOT) ? '0 : n_tail_q + 1'b1;
				n_cnt_q  <= n_cnt_q + 1'b1;
			end
			if (n_re) begin
				n_head_q <= (n_head_q == LAST_SLOT) ? '0 : n_head_q + 1'b1;
				n_cnt_q  <= n_cnt_q - 1'b1;
			end
		end
	end

	// pending response fields
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			cls_q    <= cls_d;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfifo_pkg::FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and outputs
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			pfifo_pkg::FSM_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = pfifo_pkg::FSM_RESP;
				end
			end
			pfifo_pkg::FSM_RESP: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = pfifo_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_d = pfifo_pkg::FSM_IDLE;
			end
		endcase
	end

	// result assembly, read data selected by the class that was popped
	always_comb begin
		rdata            = (cls_q == pfifo_pkg::CLS_SENIOR) ? s_rdata : n_rdata;
		res.status       = status_q;
		res.cls          = cls_q;
		res.senior_level = pfifo_pkg::LVL_W'(s_cnt_q);
		res.normal_level = pfifo_pkg::LVL_W'(n_cnt_q);
		if (status_q == pfifo_pkg::RS_SERVED) begin
			res.tag = pfifo_pkg::TAG_W'(rdata[TAG_BITS-1:0]);
			res.age = rdata[DW-1:TAG_BITS];
		end else begin
			res.tag = '0;
			res.age = '0;
		end
	end

`ifndef SYNTH
	// occupancy never passes the queue depth
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(s_cnt_q <= FULL_CNT) && (n_cnt_q <= FULL_CNT))
		else $error("queue count beyond depth");

	// an accepted request always leads to a pending response
	a_accept_resp: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == pfifo_pkg::FSM_RESP))
		else $error("accepted request without response");

	// a pop of the normal queue only happens when the senior queue is empty
	a_priority: assert property (@(posedge clk) disable iff (!arst_n)
		n_re |-> (s_empty && !s_re))
		else $error("normal queue served ahead of senior queue");

	// counts only move when a request is accepted
	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> ($stable(s_cnt_q) && $stable(n_cnt_q)))
		else $error("queue count changed without a request");
`endif

endmodule

`default_nettype wire

// ===== rtl/two_class_priority_fifo_top.sv =====
// ----------------------------------------------------------------------------
// two_class_priority_fifo_top
// two queues of tagged entries served by strict priority, apb threshold
// ----------------------------------------------------------------------------
// usage:
//  - the slave stream carries one request word: s_tuser picks add or serve,
//    s_tdata holds the tag and age of an entry to add
//  - an add goes to the senior queue when its age is at or above the apb
//    threshold register (address 0), otherwise to the normal queue
//  - a serve pops the senior head if there is one, else the normal head
//  - the master stream returns one response word per request, with status,
//    served entry, queue class and both occupancy levels
//  - a response passes the controller's response state and then the output
//    register before m_tvalid rises; a new request is taken only once the
//    controller is back in idle, after the last response has gone to the
//    output register
//  - a stalled master keeps its word in the output register; one further
//    request is accepted and then waits with its response until room frees
//  - reset empties both queues and loads the threshold with 60; the ram
//    contents are not cleared, so no clearing pass is needed
// ----------------------------------------------------------------------------
`default_nettype none

module two_class_priority_fifo_top #(
	parameter int QUEUE_DEPTH = pfifo_pkg::DEF_QUEUE_DEPTH,
	parameter int TAG_BITS    = pfifo_pkg::DEF_TAG_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // customer_tag[31:0], age[39:32]
	input  wire logic [0:0]  s_tuser,   // req_type[0]
	// response stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [55:0] m_tdata,   // served_tag[31:0], served_age[39:32],
	                                    // senior_level[47:40], normal_level[55:48]
	output logic      [2:0]  m_tuser,   // resp_status[1:0], entry_class[2]
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	logic [pfifo_pkg::AGE_W-1:0] thr_q;
	logic                        res_valid, res_take;
	pfifo_pkg::pfifo_res_t       res, out_q;
	logic                        out_valid_q;

	// threshold register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= pfifo_pkg::SENIOR_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == pfifo_pkg::REG_THRESHOLD)) begin
			thr_q <= pwdata[pfifo_pkg::AGE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == pfifo_pkg::REG_THRESHOLD) begin
			prdata = 32'(thr_q);
		end
	end

	// queue controller
	pfifo_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH), .TAG_BITS(TAG_BITS)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.req_type     (pfifo_pkg::req_t'(s_tuser[0])),
		.customer_tag (s_tdata[31:0]),
		.age          (s_tdata[39:32]),
		.threshold    (thr_q),
		.res_take     (res_take),
		.res_valid    (res_valid),
		.res          (res)
	);

	// output register
	assign res_take = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			out_q <= res;
		end
	end

	// stream packing
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.normal_level, out_q.senior_level, out_q.age, out_q.tag};
	assign m_tuser  = {out_q.cls, out_q.status};

endmodule

`default_nettype wire

// ===== tb/two_class_priority_fifo_top_test.sv =====
// ----------------------------------------------------------------------------
// two_class_priority_fifo_top_test
// self-checking bench for the strict-priority two-queue fifo
// ----------------------------------------------------------------------------
// requests go in on the slave stream from a pending queue, each accepted
// word is run through a local model of both queues and the threshold, and
// every response word is checked field by field against the oldest predicted
// response. the threshold is rewritten over apb between phases, with a
// readback, and phases range from filling the queues to draining them.
// ----------------------------------------------------------------------------

module two_class_priority_fifo_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH      = pfifo_pkg::DEF_QUEUE_DEPTH;
	localparam int CYCLE_CAP  = 200000;
	localparam int HOLD_LEN   = 300;
	localparam logic [2:0] ADDR_THRESHOLD = {pfifo_pkg::REG_THRESHOLD, 2'b00};

	// one request word
	typedef struct {
		pfifo_pkg::req_t             kind;
		logic [pfifo_pkg::TAG_W-1:0] tag;
		logic [pfifo_pkg::AGE_W-1:0] age;
	} pf_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	two_class_priority_fifo_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// queues of the bench
	pf_req_t               req_pending[$];
	pfifo_pkg::pfifo_res_t resp_expected[$];
	pf_req_t               cur_req;
	bit                    req_taken = 1'b0;
	bit                    calm = 1'b0;
	bit                    hold_req = 1'b0;
	int                    hold_left = 0;
	int                    errors = 0;
	int                    cycles = 0;

	// model state: index 0 normal queue, 1 senior queue
	logic [39:0]                 slot_mem [2][DEPTH];
	int                          q_head [2];
	int                          q_tail [2];
	int                          q_fill [2];
	logic [pfifo_pkg::AGE_W-1:0] age_threshold;

	// clock
	initial begin
		forever #6 clk = ~clk;
	end

	// model of one request: updates the queues and returns the response
	function automatic pfifo_pkg::pfifo_res_t fifo_response(pf_req_t r);
		pfifo_pkg::pfifo_res_t e;
		int c;
		e.status = pfifo_pkg::RS_EMPTY;
		e.tag    = '0;
		e.age    = '0;
		e.cls    = pfifo_pkg::CLS_NORMAL;
		if (r.kind == pfifo_pkg::REQ_ADD) begin
			c = (r.age >= age_threshold) ? 1 : 0;
			e.cls = pfifo_pkg::cls_t'(c);
			if (q_fill[c] >= DEPTH) begin
				e.status = pfifo_pkg::RS_FULL;
			end else begin
				slot_mem[c][q_tail[c]] = {r.age, r.tag};
				q_tail[c] = (q_tail[c] + 1) % DEPTH;
				q_fill[c]++;
				e.status = pfifo_pkg::RS_ADDED;
			end
		end else if (q_fill[1] != 0 || q_fill[0] != 0) begin
			// senior queue has strict priority
			c = (q_fill[1] != 0) ? 1 : 0;
			{e.age, e.tag} = slot_mem[c][q_head[c]];
			q_head[c] = (q_head[c] + 1) % DEPTH;
			q_fill[c]--;
			e.cls = pfifo_pkg::cls_t'(c);
			e.status = pfifo_pkg::RS_SERVED;
		end
		e.senior_level = q_fill[1][pfifo_pkg::LVL_W-1:0];
		e.normal_level = q_fill[0][pfifo_pkg::LVL_W-1:0];
		return e;
	endfunction

	// accepted request words go through the model
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			resp_expected.push_back(fifo_response(cur_req));
			req_taken = 1'b1;
		end
	end

	// request driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || req_taken) begin
				if (req_pending.size() != 0 && (calm || $urandom_range(0, 99) >= 14)) begin
					cur_req = req_pending.pop_front();
					s_tdata  <= {cur_req.age, cur_req.tag};
					s_tuser  <= cur_req.kind;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			req_taken = 1'b0;
		end
	end

	// response ready, with random stalls and a long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_LEN;
			hold_req = 1'b0;
		end
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= calm || ($urandom_range(0, 99) >= 14);
		end
	end

	task automatic field_chk(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, act_v);
			errors++;
		end
	endtask

	// response monitor
	always @(posedge clk) begin
		pfifo_pkg::pfifo_res_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (resp_expected.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual tdata %h tuser %h",
					$realtime, m_tdata, m_tuser);
				errors++;
			end else begin
				e = resp_expected.pop_front();
				field_chk("resp_status",  32'(e.status),       32'(m_tuser[1:0]));
				field_chk("served_tag",   32'(e.tag),          32'(m_tdata[31:0]));
				field_chk("served_age",   32'(e.age),          32'(m_tdata[39:32]));
				field_chk("entry_class",  32'(e.cls),          32'(m_tuser[2]));
				field_chk("senior_level", 32'(e.senior_level), 32'(m_tdata[47:40]));
				field_chk("normal_level", 32'(e.normal_level), 32'(m_tdata[55:48]));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_CAP) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// apb write of the threshold, then read it back
	task automatic set_threshold(input logic [pfifo_pkg::AGE_W-1:0] thr);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_THRESHOLD;
		pwdata  <= {24'd0, thr};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		age_threshold = thr;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {24'd0, thr}) begin
			$display("%0t: threshold readback mismatch, expected %h, actual %h",
				$realtime, {24'd0, thr}, prdata);
			errors++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// wait until every word is sent and every response is back
	task automatic drain();
		@(posedge clk);
		while (req_pending.size() != 0 || s_tvalid || resp_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic push_req(input pfifo_pkg::req_t kind,
			input logic [pfifo_pkg::TAG_W-1:0] tag,
			input logic [pfifo_pkg::AGE_W-1:0] age);
		pf_req_t r;
		r.kind = kind;
		r.tag  = tag;
		r.age  = age;
		req_pending.push_back(r);
	endtask

	// one random phase; ages lean toward the threshold and the extremes
	task automatic run_phase(input logic [pfifo_pkg::AGE_W-1:0] thr, input int add_pct,
			input int n, input bit stall_out, input bit no_idle);
		int a;
		int pick;
		logic [pfifo_pkg::TAG_W-1:0] tag;
		set_threshold(thr);
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				a = int'(thr) + int'($urandom_range(0, 2)) - 1;
				if (a < 0) a = 0;
				if (a > 255) a = 255;
			end else if (pick < 30) begin
				a = 0;
			end else if (pick < 35) begin
				a = 255;
			end else begin
				a = $urandom_range(0, 255);
			end
			pick = $urandom_range(0, 99);
			tag = (pick < 4) ? '0 : (pick < 8) ? '1 : pfifo_pkg::TAG_W'($urandom);
			push_req(($urandom_range(0, 99) < add_pct) ? pfifo_pkg::REQ_ADD
			                                           : pfifo_pkg::REQ_SERVE,
				tag, a[7:0]);
		end
		calm = no_idle;
		if (stall_out)
			hold_req = 1'b1;
		drain();
		calm = 1'b0;
	endtask

	// stimulus
	initial begin
		for (int c = 0; c < 2; c++) begin
			q_head[c] = 0;
			q_tail[c] = 0;
			q_fill[c] = 0;
		end
		age_threshold = pfifo_pkg::SENIOR_RESET;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// directed: reset threshold, empty serve, class boundary, extremes
		push_req(pfifo_pkg::REQ_SERVE, '1, 8'hff);
		push_req(pfifo_pkg::REQ_ADD, '0, 8'd59);
		push_req(pfifo_pkg::REQ_ADD, '1, 8'd60);
		push_req(pfifo_pkg::REQ_ADD, 32'ha5a5_5a5a, 8'd255);
		push_req(pfifo_pkg::REQ_ADD, 32'h5a5a_a5a5, 8'd0);
		push_req(pfifo_pkg::REQ_SERVE, '0, 8'd0);
		push_req(pfifo_pkg::REQ_SERVE, '0, 8'd0);
		push_req(pfifo_pkg::REQ_SERVE, '0, 8'd0);
		push_req(pfifo_pkg::REQ_SERVE, '0, 8'd0);
		push_req(pfifo_pkg::REQ_SERVE, '0, 8'd0);
		drain();

		// threshold zero: every age is senior
		set_threshold(8'd0);
		push_req(pfifo_pkg::REQ_ADD, 32'h0000_0001, 8'd0);
		push_req(pfifo_pkg::REQ_ADD, 32'h8000_0000, 8'd128);
		push_req(pfifo_pkg::REQ_SERVE, '0, 8'd0);
		push_req(pfifo_pkg::REQ_SERVE, '0, 8'd0);
		push_req(pfifo_pkg::REQ_SERVE, '0, 8'd0);
		drain();

		// threshold at the top: only age 255 is senior
		set_threshold(8'd255);
		push_req(pfifo_pkg::REQ_ADD, 32'h1234_5678, 8'd254);
		push_req(pfifo_pkg::REQ_ADD, 32'h8765_4321, 8'd255);
		push_req(pfifo_pkg::REQ_SERVE, '0, 8'd0);
		push_req(pfifo_pkg::REQ_SERVE, '0, 8'd0);
		push_req(pfifo_pkg::REQ_SERVE, '0, 8'd0);
		drain();

		// random phases: fill to full, drain, balanced, with wrap of pointers
		run_phase(8'd0,   90, 220, 1'b0, 1'b0);
		run_phase(8'd255, 90, 220, 1'b0, 1'b0);
		run_phase(8'd60,  20, 200, 1'b0, 1'b0);
		run_phase(8'($urandom_range(1, 254)), 50, 150, 1'b1, 1'b0);
		run_phase(8'd1,   85, 150, 1'b0, 1'b1);
		run_phase(8'($urandom_range(0, 255)), 15, 160, 1'b0, 1'b0);
		run_phase(8'd60,  50, 150, 1'b1, 1'b0);

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
